// ----- src/upc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec package
// Shared types, character constants and classification functions.
// ----------------------------------------------------------------------------
package upc_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COMPONENT_MODE = 2'd1;

  // Characters with a special role.
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;

  // Error codes carried with a result.
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TRUNC   = 2'd1,
    ERR_INVALID = 2'd2
  } err_e;

  // A queued command produces one or three result bytes.
  typedef enum logic {
    CMD_SINGLE,
    CMD_TRIPLE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    err_e       err;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic direction;
    logic component_mode;
  } cfg_t;

  // Letters and digits.
  function automatic logic is_alnum(input logic [7:0] c);
    logic r;
    r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h41 && c <= 8'h5A);
    return r;
  endfunction

  // Marks: - _ . ! ~ * ' ( )
  function automatic logic is_mark(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Reserved characters of a full URI: ; / ? : @ & = + $ , #
  function automatic logic is_uri_special(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C,
      8'h23: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_unescaped(input logic [7:0] c, input logic comp);
    logic r;
    r = is_alnum(c) || is_mark(c) || (!comp && is_uri_special(c));
    return r;
  endfunction

  function automatic logic is_reserved(input logic [7:0] c, input logic comp);
    logic r;
    r = (c == 8'h00) || (!comp && is_uri_special(c));
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
        (c >= 8'h41 && c <= 8'h46);
    return r;
  endfunction

  // Value of a hex digit; only the low nibble is kept.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // Uppercase hex character for a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CHR_ZERO + {4'd0, n};
    end else begin
      r = CHR_UPPER_A + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ----- src/upc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec front end
// Accepts string bytes, tracks escape state and issues one command per
// byte that produces results.
// ----------------------------------------------------------------------------
module upc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  upc_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          push_o,
  output upc_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PERCENT = 2'd1,
    PH_DIGIT   = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic       skip_q, skip_d;
  logic       emit;
  logic       accept;
  logic [7:0] dec_val;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && emit;
  assign dec_val    = {upc_pkg::hex_val(first_q), upc_pkg::hex_val(in_byte_i)};

  // Classify the byte against the current escape state.
  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    skip_d      = skip_q;
    emit        = 1'b0;
    cmd_o.kind  = upc_pkg::CMD_SINGLE;
    cmd_o.byte0 = in_byte_i;
    cmd_o.byte1 = upc_pkg::CHR_PERCENT;
    cmd_o.byte2 = in_byte_i;
    cmd_o.err   = upc_pkg::ERR_NONE;
    cmd_o.done  = in_last_i;
    priority if (skip_q) begin
      // Dropping the rest of a failed string.
      if (in_last_i) begin
        skip_d = 1'b0;
      end
    end else if (!cfg_i.direction) begin
      phase_d = PH_IDLE;
      emit    = 1'b1;
      if (!upc_pkg::is_unescaped(in_byte_i, cfg_i.component_mode)) begin
        cmd_o.kind  = upc_pkg::CMD_TRIPLE;
        cmd_o.byte0 = upc_pkg::CHR_PERCENT;
        cmd_o.byte1 = upc_pkg::hex_char(in_byte_i[7:4]);
        cmd_o.byte2 = upc_pkg::hex_char(in_byte_i[3:0]);
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (in_byte_i != upc_pkg::CHR_PERCENT) begin
            emit = 1'b1;
          end else if (in_last_i) begin
            emit      = 1'b1;
            cmd_o.err = upc_pkg::ERR_TRUNC;
          end else begin
            phase_d = PH_PERCENT;
          end
        end
        PH_PERCENT: begin
          if (in_last_i) begin
            emit      = 1'b1;
            cmd_o.err = upc_pkg::ERR_TRUNC;
          end else if (!upc_pkg::is_hex(in_byte_i)) begin
            emit      = 1'b1;
            cmd_o.err = upc_pkg::ERR_INVALID;
          end else begin
            first_d = in_byte_i;
            phase_d = PH_DIGIT;
          end
        end
        default: begin
          // Second digit; the first one is always a valid hex digit here.
          phase_d = PH_IDLE;
          emit    = 1'b1;
          if (!upc_pkg::is_hex(first_q) || !upc_pkg::is_hex(in_byte_i)) begin
            cmd_o.err = upc_pkg::ERR_INVALID;
          end else if (!upc_pkg::is_reserved(dec_val, cfg_i.component_mode)) begin
            cmd_o.byte0 = dec_val;
          end else begin
            cmd_o.kind  = upc_pkg::CMD_TRIPLE;
            cmd_o.byte0 = upc_pkg::CHR_PERCENT;
            cmd_o.byte1 = first_q;
            cmd_o.byte2 = in_byte_i;
          end
        end
      endcase
      // An error ends the string's output and drops what follows.
      if (emit && cmd_o.err != upc_pkg::ERR_NONE) begin
        cmd_o.byte0 = 8'h00;
        cmd_o.done  = 1'b1;
        phase_d     = PH_IDLE;
        skip_d      = !in_last_i;
      end
    end
  end

  // Escape state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      first_q <= 8'h00;
      skip_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      first_q <= first_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// ----- src/upc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec command queue
// Small FIFO that decouples the front end from the output serializer.
// ----------------------------------------------------------------------------
module upc_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output upc_pkg::cmd_t cmd_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  upc_pkg::cmd_t     mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [AddrW:0]    count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (AddrW+1)'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/upc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec back end
// Expands queued commands into result bytes, one per cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module upc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  upc_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic [1:0]    error_code_o,
  output logic          string_done_o
);

  logic [1:0] sub_q, sub_d;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_last_q, done_q;
  logic [1:0] err_q;
  logic       load;
  logic       final_sub;
  logic [7:0] sel_byte;

  assign load      = q_valid_i && (!valid_q || out_ready_i);
  assign final_sub = (cmd_i.kind == upc_pkg::CMD_SINGLE) || (sub_q == 2'd2);
  assign pop_o     = load && final_sub;
  assign sub_d     = final_sub ? 2'd0 : sub_q + 2'd1;

  // Pick the byte of the current command.
  always_comb begin
    unique case (sub_q)
      2'd0:    sel_byte = cmd_i.byte0;
      2'd1:    sel_byte = cmd_i.byte1;
      default: sel_byte = cmd_i.byte2;
    endcase
  end

  // Control: byte position and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        sub_q   <= sub_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= sel_byte;
      run_last_q <= final_sub;
      err_q      <= cmd_i.err;
      done_q     <= final_sub && cmd_i.done;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = run_last_q;
  assign error_code_o  = err_q;
  assign string_done_o = done_q;

endmodule

// ----- src/uri_percent_codec_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec
// Percent-encodes or percent-decodes a byte string, one byte per request.
//
//   Channel   Dir  Signals                    Contents
//   s_axis    in   tvalid tready tdata tlast  tdata[7:0] in_byte, tlast in_last
//   m_axis    out  tvalid tready tdata tuser  tdata[7:0] out_byte,
//                  tlast                      tuser run_last/error_code,
//                                             tlast string_done
//   cfg       in   valid ready index data     index 0 direction, 1 component_mode
//
// The output register delivers one result byte per cycle while the result
// stream is not stalled; a byte gives one result, an escape gives three.
// The front end takes a byte each cycle while the four-entry command queue
// has room, independently of output stalls. Reset clears the escape state,
// the queue and the output valid; both configuration registers reset to 0.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module uri_percent_codec_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration writes.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [upc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic                         cfg_data_i,
  // Input stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] in_byte
  input  logic                         s_axis_tlast,
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]                   m_axis_tuser,  // [0] run_last, [2:1] error_code
  output logic                         m_axis_tlast
);

  upc_pkg::cfg_t cfg_q;
  upc_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_full, q_valid;
  logic          run_last;
  logic [1:0]    error_code;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == upc_pkg::REG_DIRECTION) begin
        cfg_q.direction <= cfg_data_i;
      end
      if (cfg_index_i == upc_pkg::REG_COMPONENT_MODE) begin
        cfg_q.component_mode <= cfg_data_i;
      end
    end
  end

  upc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  upc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  upc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .run_last_o    (run_last),
    .error_code_o  (error_code),
    .string_done_o (m_axis_tlast)
  );

  assign m_axis_tuser = {error_code, run_last};

endmodule

// ----- src/upc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec port checker
// Checks result stream properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module upc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // An error result is a single zero byte that ends the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:1] != upc_pkg::ERR_NONE |->
    m_axis_tuser[0] && m_axis_tlast && m_axis_tdata == 8'h00)
    else $error("malformed error result");

  // The end of a string is always the end of a request's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("string end inside a request's results");

  // Only defined error codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3)
    else $error("undefined error code");

endmodule

bind uri_percent_codec_top upc_checker u_upc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent codec testbench
// Streams byte strings through the codec in encode and decode direction, in
// full-URI and component mode, and compares the flags and error code of every
// result, and the byte of each non-error one, against a cycle-free prediction
// of the codec kept here. A short directed run covers the escape corner cases;
// random strings follow under several source-idle and sink-stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned PHASE_ITEMS  = 28;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Idling patterns: which of sender idle and receiver stall percentages apply.
  localparam int unsigned IDLE_NONE = 0;
  localparam int unsigned IDLE_SRC  = 1;
  localparam int unsigned IDLE_SINK = 2;
  localparam int unsigned IDLE_BOTH = 3;

  localparam string MARK_CHARS   = "-_.!~*'()";
  localparam string URI_SPECIALS = ";/?:@&=+$,#";
  localparam string ENCODE_PICKS = ";/?:@&=+$,#-_.!~*'()`% aZ09";

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct {
    logic [7:0]    data;
    logic          run_last;
    upc_pkg::err_e err;
    logic          done;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready_o;
  logic [upc_pkg::CfgIdxW-1:0]   cfg_index = '0;
  logic                          cfg_data  = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    in_data   = '0;
  logic                          in_last   = 1'b0;
  logic                          m_axis_tvalid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    m_axis_tdata;
  logic [2:0]                    m_axis_tuser;
  logic                          m_axis_tlast;

  // Bytes waiting to be sent and results the codec still owes.
  in_item_t    byte_q[$];
  result_t     result_q[$];

  // Predicted codec state and configuration.
  logic        cfg_dir   = 1'b0;
  logic        cfg_comp  = 1'b0;
  logic [1:0]  esc_phase = 2'd0;
  logic [7:0]  esc_first = 8'h00;
  logic        skip_rest = 1'b0;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        in_taken       = 1'b0;
  int unsigned fail_cnt       = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned n_items        = 0;
  int unsigned n_results      = 0;
  int unsigned n_errors       = 0;
  int unsigned n_strings      = 0;

  uri_percent_codec_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .s_axis_tlast  (in_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Character classes of the prediction
  // ---------------------------------------------------------------------------
  function automatic bit in_set(input logic [7:0] c, input string s);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == c) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic bit char_is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit char_passes(input logic [7:0] c, input logic comp);
    bit alnum;
    alnum = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    return alnum || in_set(c, MARK_CHARS) || (!comp && in_set(c, URI_SPECIALS));
  endfunction

  // Decoded values that must stay escaped.
  function automatic bit char_kept(input logic [7:0] c, input logic comp);
    return (c == 8'h00) || (!comp && in_set(c, URI_SPECIALS));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c >= "a") begin
      v = c - "a" + 8'd10;
    end else begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] upper_hex(input logic [3:0] n);
    return (n < 4'd10) ? (upc_pkg::CHR_ZERO + {4'd0, n})
                       : (upc_pkg::CHR_UPPER_A + {4'd0, n} - 8'd10);
  endfunction

  // Hex digit with random letter case, for stimulus.
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] base;
    base = ($urandom_range(1) == 0) ? "a" : upc_pkg::CHR_UPPER_A;
    return (n < 4'd10) ? (upc_pkg::CHR_ZERO + {4'd0, n}) : (base + {4'd0, n} - 8'd10);
  endfunction

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  task automatic want_result(input logic [7:0] data, input logic rl,
                             input upc_pkg::err_e err, input logic done);
    result_t r;
    r.data = data;
    r.run_last = rl;
    r.err = err;
    r.done = done;
    result_q.push_back(r);
  endtask

  // A failed string gives one error result and drops what is left of it.
  task automatic flag_error(input upc_pkg::err_e err, input logic last);
    want_result(8'h00, 1'b1, err, 1'b1);
    esc_phase = 2'd0;
    skip_rest = !last;
  endtask

  task automatic predict_step(input logic [7:0] c, input logic last);
    logic [7:0] v;
    if (skip_rest) begin
      if (last) begin
        skip_rest = 1'b0;
      end
    end else if (!cfg_dir) begin
      // Encoding abandons any escape left open by decoding.
      esc_phase = 2'd0;
      if (char_passes(c, cfg_comp)) begin
        want_result(c, 1'b1, upc_pkg::ERR_NONE, last);
      end else begin
        want_result(upc_pkg::CHR_PERCENT, 1'b0, upc_pkg::ERR_NONE, 1'b0);
        want_result(upper_hex(c[7:4]), 1'b0, upc_pkg::ERR_NONE, 1'b0);
        want_result(upper_hex(c[3:0]), 1'b1, upc_pkg::ERR_NONE, last);
      end
    end else if (esc_phase == 2'd0) begin
      if (c != upc_pkg::CHR_PERCENT) begin
        want_result(c, 1'b1, upc_pkg::ERR_NONE, last);
      end else if (last) begin
        flag_error(upc_pkg::ERR_TRUNC, last);
      end else begin
        esc_phase = 2'd1;
      end
    end else if (esc_phase == 2'd1) begin
      if (last) begin
        flag_error(upc_pkg::ERR_TRUNC, last);
      end else if (!char_is_hex(c)) begin
        flag_error(upc_pkg::ERR_INVALID, last);
      end else begin
        esc_first = c;
        esc_phase = 2'd2;
      end
    end else begin
      esc_phase = 2'd0;
      if (!char_is_hex(esc_first) || !char_is_hex(c)) begin
        flag_error(upc_pkg::ERR_INVALID, last);
      end else begin
        v = {hex_value(esc_first), hex_value(c)};
        if (!char_kept(v, cfg_comp)) begin
          want_result(v, 1'b1, upc_pkg::ERR_NONE, last);
        end else begin
          want_result(upc_pkg::CHR_PERCENT, 1'b0, upc_pkg::ERR_NONE, 1'b0);
          want_result(esc_first, 1'b0, upc_pkg::ERR_NONE, 1'b0);
          want_result(c, 1'b1, upc_pkg::ERR_NONE, last);
        end
      end
    end
  endtask

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    fail_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver and request capture
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= byte_q[0].data;
        in_last  <= byte_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken = in_valid && s_axis_tready;
    if (in_taken) begin
      byte_q.delete(0);
      predict_step(in_data, in_last);
      n_items++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && out_ready) begin
      n_results++;
      if (m_axis_tuser[2:1] != upc_pkg::ERR_NONE) begin
        n_errors++;
      end
      if (result_q.size() == 0) begin
        report($sformatf("result byte %02h with no request pending", m_axis_tdata));
      end else begin
        want = result_q.pop_front();
        // The byte of an error result carries no meaning.
        if ((want.err == upc_pkg::ERR_NONE && m_axis_tdata != want.data) ||
            m_axis_tuser[0] != want.run_last || m_axis_tuser[2:1] != want.err ||
            m_axis_tlast != want.done) begin
          report($sformatf({"result %0d: got byte %02h rl %0d err %0d done %0d, ",
                            "want %02h %0d %0d %0d"},
                           n_results, m_axis_tdata, m_axis_tuser[0], m_axis_tuser[2:1],
                           m_axis_tlast, want.data, want.run_last, want.err, want.done));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ERROR: no progress after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [upc_pkg::CfgIdxW-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    if (idx == upc_pkg::REG_DIRECTION) begin
      cfg_dir = val;
    end else if (idx == upc_pkg::REG_COMPONENT_MODE) begin
      cfg_comp = val;
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic dir, input logic comp, input int unsigned idle);
    write_reg(upc_pkg::REG_DIRECTION, dir);
    write_reg(upc_pkg::REG_COMPONENT_MODE, comp);
    case (idle)
      IDLE_SRC: begin
        src_idle_pct = 62;
        sink_stall_pct = 0;
      end
      IDLE_SINK: begin
        src_idle_pct = 0;
        sink_stall_pct = 62;
      end
      IDLE_BOTH: begin
        src_idle_pct = 32;
        sink_stall_pct = 32;
      end
      default: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
    endcase
  endtask

  // Wait until every byte is sent, every result is back and the codec is quiet.
  task automatic settle();
    while (byte_q.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    while (result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data = b;
    it.last = last;
    byte_q.push_back(it);
  endtask

  task automatic add_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i], last && (i == s.len() - 1));
    end
  endtask

  // One random string; decode strings are mostly well-formed escapes.
  task automatic add_string(input logic dir, output int unsigned n);
    logic [7:0]  str_q[$];
    logic [7:0]  v;
    int unsigned pieces;
    int unsigned r;
    int unsigned k;
    pieces = $urandom_range(6, 1);
    for (int i = 0; i < pieces; i++) begin
      r = $urandom_range(99);
      if (!dir) begin
        str_q.push_back((r < 30) ? pick_char(ENCODE_PICKS) : 8'($urandom_range(255)));
      end else if (r < 55) begin
        k = $urandom_range(47);
        if (k < URI_SPECIALS.len()) begin
          v = URI_SPECIALS[k];
        end else if (k == URI_SPECIALS.len()) begin
          v = 8'h00;
        end else begin
          v = 8'($urandom_range(255));
        end
        str_q.push_back(upc_pkg::CHR_PERCENT);
        str_q.push_back(hex_digit(v[7:4]));
        str_q.push_back(hex_digit(v[3:0]));
      end else if (r < 85) begin
        str_q.push_back(8'($urandom_range(255)));
      end else if (r < 95) begin
        // Escape with arbitrary digits, usually broken.
        str_q.push_back(upc_pkg::CHR_PERCENT);
        str_q.push_back(8'($urandom_range(255)));
        str_q.push_back(($urandom_range(1) == 0) ? hex_digit(4'($urandom_range(15)))
                                                 : 8'($urandom_range(255)));
      end else begin
        str_q.push_back(upc_pkg::CHR_PERCENT);
      end
    end
    for (int j = 0; j < str_q.size(); j++) begin
      add_byte(str_q[j], j == str_q.size() - 1);
    end
    n = str_q.size();
    n_strings++;
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned cnt;
    logic [1:0]  combo;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Encode, full URI: letters, marks, specials, the byte extremes.
    configure(1'b0, 1'b0, IDLE_NONE);
    add_text("a~#", 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    settle();
    // Encode, component: specials and backtick get escaped, marks pass.
    configure(1'b0, 1'b1, IDLE_NONE);
    add_text("#;`(", 1'b1);
    settle();
    // Decode, full URI: a reserved escape is kept, bad second digit on the
    // last byte, and a lone percent sign at the end of a string.
    configure(1'b1, 1'b0, IDLE_NONE);
    add_text("%2F%4g", 1'b1);
    add_text("%", 1'b1);
    settle();
    // Decode, component: lowercase escape decodes, %00 stays, a bad first
    // digit drops the rest, and an open escape is left for the next phase.
    configure(1'b1, 1'b1, IDLE_NONE);
    add_text("%2f%00%G", 1'b0);
    add_text("q", 1'b1);
    add_byte(upc_pkg::CHR_PERCENT, 1'b0);
    settle();

    // Random strings under every setting and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      combo = 2'(p);
      configure(combo[0], combo[1], (p + p / 4) % 4);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        add_string(combo[0], n);
        cnt += n;
      end
      // Sometimes leave a string open across the register change.
      if ($urandom_range(1) == 1) begin
        add_byte(combo[0] ? upc_pkg::CHR_PERCENT : 8'($urandom_range(255)), 1'b0);
      end
      settle();
    end

    $display("Sent %0d bytes in %0d random strings plus directed cases;",
             n_items, n_strings);
    $display("got %0d results, %0d of them errors.", n_results, n_errors);
    $display("Both directions and both modes ran under four idle and stall patterns.");
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/upc_pkg.sv
src/upc_front.sv
src/upc_queue.sv
src/upc_back.sv
src/uri_percent_codec_top.sv
src/upc_checker.sv
tb/sv/tb_top.sv
